[hw/rtl/imr_pkg.sv]
// Shared types and constants for the impedance magnitude and range select block.
package imr_pkg;

   // Reset values of the threshold registers.
   localparam logic [15:0] UPPER_RESET = 16'd15000;
   localparam logic [15:0] LOWER_RESET = 16'd2500;

   // Register indexes on the configuration port.
   localparam logic REG_UPPER = 1'b0;
   localparam logic REG_LOWER = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_VALID       = 2'd0;
   localparam logic [1:0] STATUS_SWITCH_HIGH = 2'd1;
   localparam logic [1:0] STATUS_SWITCH_LOW  = 2'd2;

   // Range codes.
   localparam logic RANGE_LOW  = 1'b0;
   localparam logic RANGE_HIGH = 1'b1;

   // Divide by ten as a multiply by ceil(2^19 / 10) and a shift; exact for 16-bit values.
   localparam logic [15:0] DIV10_RECIP = 16'd52429;
   localparam int          DIV10_SHIFT = 19;

   // The root of a 32-bit value takes one step per result bit.
   localparam int ROOT_STEPS = 16;
   localparam int STEP_BITS  = $clog2(ROOT_STEPS);

   // Status of the square root unit as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } root_stat_type;

endpackage

[hw/rtl/imr_sqrt.sv]
// Bit-by-bit restoring integer square root of a 32-bit value, one result bit per cycle.
module imr_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [31:0]           radicand,
   output logic [15:0]           root,
   output imr_pkg::root_stat_type stat
);
   import imr_pkg::*;

   logic [31:0]          op_ff, op_in;
   logic [31:0]          res_ff, res_in;
   logic [31:0]          bit_ff, bit_in;
   logic [STEP_BITS-1:0] count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [31:0]          trial;

   // One trial subtraction per cycle against the partial root plus the current bit.
   assign trial = res_ff + bit_ff;

   always_comb begin
      op_in    = op_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         op_in    = radicand;
         res_in   = '0;
         bit_in   = 32'h4000_0000;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (op_ff >= trial) begin
            op_in  = op_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in   = bit_ff >> 2;
         count_in = count_ff + 1'b1;
         if (count_ff == STEP_BITS'(ROOT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff    <= op_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      count_ff <= count_in;
   end

   // The final root of a 32-bit value never exceeds 65535, so the low half holds it.
   assign root      = res_ff[15:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[hw/rtl/impedance_magnitude_range_select.sv]
// Top level: sample sequencer, shared multiplier, range logic and threshold registers.
// Each sample transferred on the req_ channel goes through these steps until its result
// is offered on the rsp_ channel: the real and imaginary parts are squared on a single
// shared 16x16 multiplier, the square root unit is started and produces the root one
// bit at a time, the finished root is taken, it is divided by ten on the same
// multiplier, and the range decision is made and the output register is loaded.
// A new sample is taken once the previous one has reached the output register; the
// range decision for a sample waits while an older result still sits unread. The range
// starts out high after reset. The thresholds sit at byte addresses 0 (upper) and 4
// (lower) and should be written only while idle.
module impedance_magnitude_range_select (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] real_part, [31:16] imag_part
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] conductivity, [16] range_now, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import imr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_START,
      ST_ROOT,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type     state_ff, state_in;
   logic [15:0]   are_ff, are_in;
   logic [15:0]   aim_ff, aim_in;
   logic [31:0]   sum_ff, sum_in;
   logic [15:0]   mag_ff, mag_in;
   logic [15:0]   quot_ff, quot_in;
   logic          range_ff, range_in;
   logic [15:0]   upper_ff, upper_in;
   logic [15:0]   lower_ff, lower_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [15:0]   rsp_cond_ff, rsp_cond_in;
   logic          rsp_range_ff, rsp_range_in;

   logic [15:0]   mult_a, mult_b;
   logic [31:0]   mult_p;
   logic          root_start;
   logic [15:0]   root;
   root_stat_type root_stat;
   logic          csr_write;
   logic          in_xfer;
   logic          out_free;

   // Square root unit.
   imr_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sum_ff),
      .root     (root),
      .stat     (root_stat)
   );

   assign root_start = (state_ff == ST_START);

   // Shared multiplier: squares of both parts, then the divide by ten.
   always_comb begin
      case (state_ff)
         ST_SQ_RE: begin
            mult_a = are_ff;
            mult_b = are_ff;
         end
         ST_SQ_IM: begin
            mult_a = aim_ff;
            mult_b = aim_ff;
         end
         ST_DIV: begin
            mult_a = mag_ff;
            mult_b = DIV10_RECIP;
         end
         default: begin
            mult_a = '0;
            mult_b = '0;
         end
      endcase
   end

   assign mult_p = {16'b0, mult_a} * {16'b0, mult_b};

   assign csr_write = csr_psel & csr_penable & csr_pwrite;
   assign in_xfer   = req_tvalid & req_tready;
   assign out_free  = ~rsp_valid_ff | rsp_tready;

   // Sequencer, range decision and output register.
   always_comb begin
      state_in      = state_ff;
      are_in        = are_ff;
      aim_in        = aim_ff;
      sum_in        = sum_ff;
      mag_in        = mag_ff;
      quot_in       = quot_ff;
      range_in      = range_ff;
      upper_in      = upper_ff;
      lower_in      = lower_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_cond_in   = rsp_cond_ff;
      rsp_range_in  = rsp_range_ff;

      // Threshold writes.
      if (csr_write) begin
         if (csr_paddr[2] == REG_UPPER) begin
            upper_in = csr_pwdata[15:0];
         end else begin
            lower_in = csr_pwdata[15:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (in_xfer) begin
               // Magnitudes of both parts; the negation of -32768 gives 32768 as unsigned.
               are_in   = req_tdata[15] ? 16'(~req_tdata[15:0] + 16'd1) : req_tdata[15:0];
               aim_in   = req_tdata[31] ? 16'(~req_tdata[31:16] + 16'd1) : req_tdata[31:16];
               state_in = ST_SQ_RE;
            end
         end
         ST_SQ_RE: begin
            sum_in   = mult_p;
            state_in = ST_SQ_IM;
         end
         ST_SQ_IM: begin
            sum_in   = sum_ff + mult_p;
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_stat.done) begin
               mag_in   = root;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quot_in  = 16'(mult_p >> DIV10_SHIFT);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cond_in  = '0;
               if (mag_ff > upper_ff && range_ff == RANGE_LOW) begin
                  range_in      = RANGE_HIGH;
                  rsp_status_in = STATUS_SWITCH_HIGH;
               end else if (mag_ff < lower_ff && range_ff == RANGE_HIGH) begin
                  range_in      = RANGE_LOW;
                  rsp_status_in = STATUS_SWITCH_LOW;
               end else begin
                  rsp_status_in = STATUS_VALID;
                  rsp_cond_in   = (range_ff == RANGE_LOW) ? quot_ff : mag_ff;
               end
               rsp_range_in = range_in;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         range_ff     <= RANGE_HIGH;
         upper_ff     <= UPPER_RESET;
         lower_ff     <= LOWER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         range_ff     <= range_in;
         upper_ff     <= upper_in;
         lower_ff     <= lower_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      are_ff        <= are_in;
      aim_ff        <= aim_in;
      sum_ff        <= sum_in;
      mag_ff        <= mag_in;
      quot_ff       <= quot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cond_ff   <= rsp_cond_in;
      rsp_range_ff  <= rsp_range_in;
   end

   // Ports.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_range_ff, rsp_cond_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = {16'b0, (csr_paddr[2] == REG_UPPER) ? upper_ff : lower_ff};

endmodule
